// ===== hdl/ubx_frame_parser_macros.svh =====
// assertion macros shared by the frame parser modules
// no dependencies; taken in by `include where assertions are written
`ifndef UBX_FRAME_PARSER_MACROS_SVH
`define UBX_FRAME_PARSER_MACROS_SVH

// property that holds at every clock edge outside reset
`define UFP_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence in the same cycle as the antecedent
`define UFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence in the cycle after the antecedent
`define UFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ufp_pkg.sv =====
// shared types, protocol constants and message classification for the frame parser
// no dependencies
package ufp_pkg;

   localparam int MAX_PAYLOAD_DEF = 128;

   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 7;
   localparam int EVENT_W = 3;
   localparam int KIND_W  = 3;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;

   // event codes
   localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
   localparam logic [EVENT_W-1:0] EV_DATA    = 3'd1;
   localparam logic [EVENT_W-1:0] EV_GOOD    = 3'd2;
   localparam logic [EVENT_W-1:0] EV_BADSUM  = 3'd3;
   localparam logic [EVENT_W-1:0] EV_TOOLONG = 3'd4;

   // message kinds
   localparam logic [KIND_W-1:0] KIND_ACK         = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NAK         = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NAV_PVT     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NAV_POSECEF = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CFG_NAV5    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_UNHANDLED   = 3'd5;

   // published class and id values
   localparam logic [BYTE_W-1:0] CLS_ACK        = 8'h05;
   localparam logic [BYTE_W-1:0] CLS_NAV        = 8'h01;
   localparam logic [BYTE_W-1:0] CLS_CFG        = 8'h06;
   localparam logic [BYTE_W-1:0] ID_ACK_ACK     = 8'h01;
   localparam logic [BYTE_W-1:0] ID_ACK_NAK     = 8'h00;
   localparam logic [BYTE_W-1:0] ID_NAV_PVT     = 8'h07;
   localparam logic [BYTE_W-1:0] ID_NAV_POSECEF = 8'h01;
   localparam logic [BYTE_W-1:0] ID_CFG_NAV5    = 8'h24;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [BYTE_W-1:0]  data_byte;
      logic [INDEX_W-1:0] data_index;
      logic [BYTE_W-1:0]  frame_class;
      logic [BYTE_W-1:0]  frame_id;
      logic [INDEX_W-1:0] frame_length;
      logic [KIND_W-1:0]  message_kind;
   } rsp_type;

   function automatic logic [KIND_W-1:0] classify(input logic [BYTE_W-1:0] cls,
                                                  input logic [BYTE_W-1:0] mid);
      logic [KIND_W-1:0] kind;
      kind = KIND_UNHANDLED;
      priority if (cls == CLS_ACK && mid == ID_ACK_ACK) begin
         kind = KIND_ACK;
      end else if (cls == CLS_ACK && mid == ID_ACK_NAK) begin
         kind = KIND_NAK;
      end else if (cls == CLS_NAV && mid == ID_NAV_PVT) begin
         kind = KIND_NAV_PVT;
      end else if (cls == CLS_NAV && mid == ID_NAV_POSECEF) begin
         kind = KIND_NAV_POSECEF;
      end else if (cls == CLS_CFG && mid == ID_CFG_NAV5) begin
         kind = KIND_CFG_NAV5;
      end else begin
         kind = KIND_UNHANDLED;
      end
      return kind;
   endfunction

endpackage

// ===== hdl/ufp_in_reg.sv =====
// input register for received bytes, one beat deep
// depends on ufp_pkg
module ufp_in_reg
   import ufp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic              take,
   output logic              hold_valid,
   output logic [BYTE_W-1:0] hold_byte
);

   logic              valid_ff;
   logic [BYTE_W-1:0] byte_ff;

   // free, or being emptied this cycle
   assign req_ready  = !valid_ff || take;
   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

endmodule

// ===== hdl/ufp_parse.sv =====
// frame phase register, running fletcher sums and result decode for one byte
// depends on ufp_pkg and ubx_frame_parser_macros.svh
`include "ubx_frame_parser_macros.svh"

module ufp_parse
   import ufp_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] rx_byte,
   output rsp_type           res
);

   localparam int LEN_W = $clog2(MAX_PAYLOAD);
   localparam logic [2*BYTE_W-1:0] MAX_LEN = (2*BYTE_W)'(MAX_PAYLOAD);

   typedef enum logic [2:0] {
      PH_IDLE, PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN_LO, PH_PAYLOAD, PH_CHECK_A
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] class_ff, class_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic [BYTE_W-1:0] len_low_ff, len_low_in;
   logic [LEN_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [LEN_W-1:0]  accepted_ff, accepted_in;
   logic [BYTE_W-1:0] sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0] sum_b_ff, sum_b_in;
   logic [BYTE_W-1:0] check_a_ff, check_a_in;

   logic [BYTE_W-1:0]   sum_a_step;
   logic [BYTE_W-1:0]   sum_b_step;
   logic [2*BYTE_W-1:0] len_full;

   function automatic logic [INDEX_W-1:0] to_index(input logic [LEN_W-1:0] v);
      logic [LEN_W+INDEX_W-1:0] wide;
      wide = (LEN_W+INDEX_W)'(v);
      return wide[INDEX_W-1:0];
   endfunction

   assign sum_a_step = BYTE_W'(sum_a_ff + rx_byte);
   assign sum_b_step = BYTE_W'(sum_b_ff + sum_a_step);
   assign len_full   = {rx_byte, len_low_ff};

   always_comb begin
      phase_in      = phase_ff;
      class_in      = class_ff;
      id_in         = id_ff;
      len_low_in    = len_low_ff;
      bytes_left_in = bytes_left_ff;
      accepted_in   = accepted_ff;
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      check_a_in    = check_a_ff;
      res           = '0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == SYNC_FIRST) begin
               phase_in = PH_SYNC1;
            end
         end
         PH_SYNC1: begin
            phase_in = (rx_byte == SYNC_SECOND) ? PH_SYNC2 : PH_IDLE;
         end
         PH_SYNC2: begin
            // sums restart on the class byte
            class_in = rx_byte;
            sum_a_in = rx_byte;
            sum_b_in = rx_byte;
            phase_in = PH_CLASS;
         end
         PH_CLASS: begin
            id_in    = rx_byte;
            sum_a_in = sum_a_step;
            sum_b_in = sum_b_step;
            phase_in = PH_ID;
         end
         PH_ID: begin
            len_low_in = rx_byte;
            sum_a_in   = sum_a_step;
            sum_b_in   = sum_b_step;
            phase_in   = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            sum_a_in = sum_a_step;
            sum_b_in = sum_b_step;
            if (len_full >= MAX_LEN) begin
               res.event_res   = EV_TOOLONG;
               res.frame_class = class_ff;
               res.frame_id    = id_ff;
               phase_in        = PH_IDLE;
            end else begin
               accepted_in   = len_full[LEN_W-1:0];
               bytes_left_in = len_full[LEN_W-1:0];
               phase_in      = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (bytes_left_ff != '0) begin
               res.event_res    = EV_DATA;
               res.data_byte    = rx_byte;
               res.data_index   = to_index(LEN_W'(accepted_ff - bytes_left_ff));
               res.frame_length = to_index(accepted_ff);
               res.frame_class  = class_ff;
               res.frame_id     = id_ff;
               sum_a_in         = sum_a_step;
               sum_b_in         = sum_b_step;
               bytes_left_in    = LEN_W'(bytes_left_ff - 1'b1);
            end else begin
               check_a_in = rx_byte;
               phase_in   = PH_CHECK_A;
            end
         end
         PH_CHECK_A: begin
            phase_in         = PH_IDLE;
            res.frame_length = to_index(accepted_ff);
            res.frame_class  = class_ff;
            res.frame_id     = id_ff;
            if (check_a_ff == sum_a_ff && rx_byte == sum_b_ff) begin
               res.event_res    = EV_GOOD;
               res.message_kind = classify(class_ff, id_ff);
            end else begin
               res.event_res = EV_BADSUM;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bytes_left_ff <= '0;
         accepted_ff   <= '0;
         class_ff      <= '0;
         id_ff         <= '0;
         len_low_ff    <= '0;
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
         check_a_ff    <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         accepted_ff   <= accepted_in;
         class_ff      <= class_in;
         id_ff         <= id_in;
         len_low_ff    <= len_low_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         check_a_ff    <= check_a_in;
      end
   end

   `UFP_ASSERT_HOLDS(a_left_within_len, clock, reset,
      bytes_left_ff <= accepted_ff, "payload countdown above frame length")
   `UFP_ASSERT_NEXT(a_report_ends_frame, clock, reset,
      step && (res.event_res == EV_GOOD || res.event_res == EV_BADSUM ||
               res.event_res == EV_TOOLONG),
      phase_ff == PH_IDLE, "frame report did not return parser to idle")
   `UFP_ASSERT_NOW(a_data_in_payload, clock, reset, res.event_res == EV_DATA,
      phase_ff == PH_PAYLOAD && bytes_left_ff != '0, "payload beat outside payload phase")
   `UFP_ASSERT_NOW(a_kind_on_good, clock, reset, res.event_res != EV_GOOD,
      res.message_kind == '0, "message kind set without good frame")

endmodule

// ===== hdl/ubx_frame_parser.sv =====
// top level of the binary gnss frame parser: input register, parser, result register
// depends on ufp_pkg, ufp_in_reg and ufp_parse
//
// throughput: one byte beat per cycle, sustained, while rsp_ready stays high
// a byte is held in the input register, then its parse result is registered in the result register once that is free
// the path between the two registers is the phase decode, one 8-bit fletcher step
// and the length compare; a stalled result still lets one more byte into the input register
// reset: synchronous, active high; clears both valid flags and returns the parser to idle
module ubx_frame_parser
   import ufp_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [EVENT_W-1:0] rsp_event_res,
   output logic [BYTE_W-1:0]  rsp_data_byte,
   output logic [INDEX_W-1:0] rsp_data_index,
   output logic [BYTE_W-1:0]  rsp_frame_class,
   output logic [BYTE_W-1:0]  rsp_frame_id,
   output logic [INDEX_W-1:0] rsp_frame_length,
   output logic [KIND_W-1:0]  rsp_message_kind
);

   // byte held in the input register
   logic              hold_valid;
   logic [BYTE_W-1:0] hold_byte;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type res;

   // result register free or draining, and a held byte moving across
   logic out_ready;
   logic advance;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign advance   = hold_valid && out_ready;

   ufp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .take        (advance),
      .hold_valid  (hold_valid),
      .hold_byte   (hold_byte)
   );

   // parse state only moves when its result is captured
   ufp_parse #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (hold_byte),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= hold_valid;
      end
      if (advance) begin
         rsp_data_ff <= res;
      end
   end

   // every byte gives one result beat, event none included
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_data_ff.event_res;
   assign rsp_data_byte    = rsp_data_ff.data_byte;
   assign rsp_data_index   = rsp_data_ff.data_index;
   assign rsp_frame_class  = rsp_data_ff.frame_class;
   assign rsp_frame_id     = rsp_data_ff.frame_id;
   assign rsp_frame_length = rsp_data_ff.frame_length;
   assign rsp_message_kind = rsp_data_ff.message_kind;

endmodule

// ===== bench/tb_ubx_frame_parser.sv =====
// self-checking bench for ubx_frame_parser: byte beats in, one result beat out per byte
// depends on ufp_pkg and the ubx_frame_parser rtl; a directed table is followed by random frames
// every result is checked field by field against an in-bench frame tracker, or a typed row's own result
`timescale 1ns / 100ps

module tb_ubx_frame_parser;
   import ufp_pkg::*;

   localparam int MAX_LEN      = MAX_PAYLOAD_DEF;
   localparam int PHASE_BEATS  = 175;   // frame bytes per idling phase, four phases
   localparam int STALL_LIMIT  = 1000;  // cycles with work outstanding but no handshake

   // parser phases as the bench tracks them
   typedef enum logic [3:0] {
      P_IDLE, P_SYNC1, P_SYNC2, P_CLASS, P_ID, P_LEN_LO, P_PAYLOAD, P_CHECK_A
   } parse_phase_type;

   // one byte to send; a typed row carries its own expected result
   typedef struct packed {
      logic        typed;
      logic [7:0]  rx;
      rsp_type     want;
   } stim_row_type;

   localparam rsp_type QUIET = '0;
   localparam rsp_type TOOLONG_FF = '{event_res: EV_TOOLONG, frame_class: 8'hFF,
                                      frame_id: 8'hFF, default: '0};
   localparam rsp_type BADSUM_PVT1 = '{event_res: EV_BADSUM, frame_class: CLS_NAV,
                                       frame_id: ID_NAV_PVT, frame_length: 7'd1,
                                       default: '0};

   // directed table: idle bytes, broken sync, empty ack frame with good checksum,
   // length exactly at the limit, one-byte nav-pvt frame with a bad checksum
   localparam stim_row_type DIRECTED_ROWS [26] = '{
      '{typed: 1'b1, rx: 8'h00, want: QUIET},        // straight after reset
      '{typed: 1'b1, rx: 8'hB5, want: QUIET},
      '{typed: 1'b1, rx: 8'hB5, want: QUIET},        // sync broken by a second b5
      '{typed: 1'b1, rx: 8'hB5, want: QUIET},
      '{typed: 1'b1, rx: 8'h62, want: QUIET},
      '{typed: 1'b0, rx: 8'h05, want: QUIET},        // ack class
      '{typed: 1'b0, rx: 8'h01, want: QUIET},
      '{typed: 1'b0, rx: 8'h00, want: QUIET},
      '{typed: 1'b0, rx: 8'h00, want: QUIET},        // empty payload
      '{typed: 1'b0, rx: 8'h06, want: QUIET},        // ck_a
      '{typed: 1'b0, rx: 8'h17, want: QUIET},        // ck_b, good ack
      '{typed: 1'b1, rx: 8'hB5, want: QUIET},
      '{typed: 1'b1, rx: 8'h62, want: QUIET},
      '{typed: 1'b0, rx: 8'hFF, want: QUIET},
      '{typed: 1'b0, rx: 8'hFF, want: QUIET},
      '{typed: 1'b0, rx: 8'h80, want: QUIET},
      '{typed: 1'b1, rx: 8'h00, want: TOOLONG_FF},   // length 128 is one too many
      '{typed: 1'b1, rx: 8'hB5, want: QUIET},
      '{typed: 1'b1, rx: 8'h62, want: QUIET},
      '{typed: 1'b0, rx: 8'h01, want: QUIET},
      '{typed: 1'b0, rx: 8'h07, want: QUIET},
      '{typed: 1'b0, rx: 8'h01, want: QUIET},
      '{typed: 1'b0, rx: 8'h00, want: QUIET},
      '{typed: 1'b0, rx: 8'hFF, want: QUIET},        // payload byte at index 0
      '{typed: 1'b0, rx: 8'h00, want: QUIET},
      '{typed: 1'b1, rx: 8'h00, want: BADSUM_PVT1}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [BYTE_W-1:0]  req_rx_byte = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [EVENT_W-1:0] rsp_event_res;
   logic [BYTE_W-1:0]  rsp_data_byte;
   logic [INDEX_W-1:0] rsp_data_index;
   logic [BYTE_W-1:0]  rsp_frame_class;
   logic [BYTE_W-1:0]  rsp_frame_id;
   logic [INDEX_W-1:0] rsp_frame_length;
   logic [KIND_W-1:0]  rsp_message_kind;

   stim_row_type feed_q [$];    // bytes waiting to be offered
   rsp_type      awaited_q [$]; // results owed by the parser, oldest first

   int err_count     = 0;
   int frame_beats   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int quiet_cycles  = 0;

   // frame tracker state, mirrors what the parser must hold
   parse_phase_type    trk_phase  = P_IDLE;
   logic [7:0]         trk_class  = '0;
   logic [7:0]         trk_id     = '0;
   logic [7:0]         trk_len_lo = '0;
   logic [INDEX_W-1:0] trk_left   = '0;
   logic [INDEX_W-1:0] trk_len    = '0;
   logic [7:0]         trk_sum_a  = '0;
   logic [7:0]         trk_sum_b  = '0;
   logic [7:0]         trk_ck_a   = '0;

   ubx_frame_parser #(
      .MAX_PAYLOAD(MAX_LEN)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_data_index   (rsp_data_index),
      .rsp_frame_class  (rsp_frame_class),
      .rsp_frame_id     (rsp_frame_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_message_kind (rsp_message_kind)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // frame tracker
   // ---------------------------------------------------------------------

   // one step of the 8-bit fletcher pair
   function automatic void fletcher_add(input logic [7:0] b);
      trk_sum_a = trk_sum_a + b;
      trk_sum_b = trk_sum_b + trk_sum_a;
   endfunction

   // message kind from the published class and id pairs
   function automatic logic [KIND_W-1:0] kind_of(input logic [7:0] cls, input logic [7:0] mid);
      logic [KIND_W-1:0] kind;
      unique case ({cls, mid})
         {CLS_ACK, ID_ACK_ACK}:     kind = KIND_ACK;
         {CLS_ACK, ID_ACK_NAK}:     kind = KIND_NAK;
         {CLS_NAV, ID_NAV_PVT}:     kind = KIND_NAV_PVT;
         {CLS_NAV, ID_NAV_POSECEF}: kind = KIND_NAV_POSECEF;
         {CLS_CFG, ID_CFG_NAV5}:    kind = KIND_CFG_NAV5;
         default:                   kind = KIND_UNHANDLED;
      endcase
      return kind;
   endfunction

   // advance the tracker by one received byte and give the result it owes
   function automatic rsp_type track_byte(input logic [7:0] b);
      rsp_type     r;
      logic [15:0] len;
      r   = QUIET;
      len = {b, trk_len_lo};
      unique case (trk_phase)
         P_IDLE: begin
            if (b == SYNC_FIRST) trk_phase = P_SYNC1;
         end
         P_SYNC1: begin
            trk_phase = (b == SYNC_SECOND) ? P_SYNC2 : P_IDLE;
         end
         P_SYNC2: begin
            // class byte opens a fresh checksum
            trk_class = b;
            trk_sum_a = '0;
            trk_sum_b = '0;
            fletcher_add(b);
            trk_phase = P_CLASS;
         end
         P_CLASS: begin
            trk_id = b;
            fletcher_add(b);
            trk_phase = P_ID;
         end
         P_ID: begin
            trk_len_lo = b;
            fletcher_add(b);
            trk_phase = P_LEN_LO;
         end
         P_LEN_LO: begin
            fletcher_add(b);
            if (len >= MAX_LEN) begin
               r.event_res = EV_TOOLONG;
               trk_phase   = P_IDLE;
            end else begin
               trk_len   = len[INDEX_W-1:0];
               trk_left  = len[INDEX_W-1:0];
               trk_phase = P_PAYLOAD;
            end
         end
         P_PAYLOAD: begin
            if (trk_left != 0) begin
               r.event_res    = EV_DATA;
               r.data_byte    = b;
               r.data_index   = trk_len - trk_left;
               r.frame_length = trk_len;
               fletcher_add(b);
               trk_left = trk_left - 1'b1;
            end else begin
               trk_ck_a  = b;
               trk_phase = P_CHECK_A;
            end
         end
         P_CHECK_A: begin
            trk_phase      = P_IDLE;
            r.frame_length = trk_len;
            if (trk_ck_a == trk_sum_a && b == trk_sum_b) begin
               r.event_res    = EV_GOOD;
               r.message_kind = kind_of(trk_class, trk_id);
            end else begin
               r.event_res = EV_BADSUM;
            end
         end
         default: begin
            trk_phase = P_IDLE;
         end
      endcase
      if (r.event_res != EV_NONE) begin
         r.frame_class = trk_class;
         r.frame_id    = trk_id;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      err_count++;
   endtask

   task automatic compare_field(input string name, input int seen, input int want);
      if (seen != want) report_mismatch($sformatf("%s got %0d, wanted %0d", name, seen, want));
   endtask

   // ---------------------------------------------------------------------
   // stimulus builders
   // ---------------------------------------------------------------------

   // queue a frame; spoil bit 0 or 1 damages ck_a or ck_b; a non-zero cut truncates it
   task automatic send_frame(input logic [7:0] cls, input logic [7:0] mid,
                             input logic [15:0] len, input logic [1:0] spoil, input int cut);
      logic [7:0] bytes [$];
      logic [7:0] ca;
      logic [7:0] cb;
      logic [7:0] pb;
      int         n;
      int         k;
      ca = '0;
      cb = '0;
      bytes.push_back(SYNC_FIRST);
      bytes.push_back(SYNC_SECOND);
      bytes.push_back(cls);
      bytes.push_back(mid);
      bytes.push_back(len[7:0]);
      bytes.push_back(len[15:8]);
      for (k = 2; k < 6; k++) begin
         ca = ca + bytes[k];
         cb = cb + ca;
      end
      // an over-long frame ends at its length, the parser expects nothing more
      if (len < MAX_LEN) begin
         for (k = 0; k < len; k++) begin
            pb = 8'($urandom_range(0, 255));
            bytes.push_back(pb);
            ca = ca + pb;
            cb = cb + ca;
         end
         bytes.push_back(spoil[0] ? ca ^ (8'h01 << $urandom_range(0, 7)) : ca);
         bytes.push_back(spoil[1] ? cb ^ (8'h01 << $urandom_range(0, 7)) : cb);
      end
      n = (cut == 0 || cut > bytes.size()) ? bytes.size() : cut;
      for (k = 0; k < n; k++) begin
         feed_q.push_back('{typed: 1'b0, rx: bytes[k], want: QUIET});
      end
      frame_beats += n;
   endtask

   // mostly well-formed frames with random content, the rest broken frames and line noise
   task automatic random_traffic(input int beat_goal);
      logic [7:0]  cls;
      logic [7:0]  mid;
      logic [15:0] len;
      logic [1:0]  spoil;
      int          pick;
      int          k;
      while (frame_beats < beat_goal) begin
         pick = $urandom_range(0, 9);
         unique case (pick)
            0: {cls, mid} = {CLS_ACK, ID_ACK_ACK};
            1: {cls, mid} = {CLS_ACK, ID_ACK_NAK};
            2: {cls, mid} = {CLS_NAV, ID_NAV_PVT};
            3: {cls, mid} = {CLS_NAV, ID_NAV_POSECEF};
            4: {cls, mid} = {CLS_CFG, ID_CFG_NAV5};
            5: {cls, mid} = {CLS_ACK, 8'($urandom_range(0, 255))};
            6: {cls, mid} = {CLS_NAV, 8'($urandom_range(0, 255))};
            default: {cls, mid} = 16'($urandom_range(0, 65535));
         endcase
         // short payloads mostly, a few long ones and a few beyond the limit
         pick = $urandom_range(0, 99);
         if (pick < 75)       len = 16'($urandom_range(0, 8));
         else if (pick < 88)  len = 16'($urandom_range(9, MAX_LEN - 1));
         else if (pick < 91)  len = 16'(MAX_LEN - 1);
         else if (pick < 94)  len = 16'(MAX_LEN);
         else if (pick < 96)  len = 16'hFFFF;
         else                 len = 16'($urandom_range(MAX_LEN + 1, 65535));
         spoil = ($urandom_range(0, 99) < 12) ? 2'($urandom_range(1, 3)) : 2'b00;
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            send_frame(cls, mid, len, spoil, 0);
         end else if (pick < 84) begin
            // truncated frame, the next frame's bytes land mid-parse
            send_frame(cls, mid, len, spoil, $urandom_range(1, 7));
         end else begin
            // noise between frames, sometimes a lone first sync byte
            for (k = $urandom_range(1, 4); k > 0; k--) begin
               feed_q.push_back('{typed: 1'b0, want: QUIET,
                                  rx: ($urandom_range(0, 3) == 0) ? SYNC_FIRST
                                                                  : 8'($urandom_range(0, 255))});
            end
         end
      end
   endtask

   // waits until every byte is taken and every result has come back
   task automatic drain_all;
      while (feed_q.size() != 0 || awaited_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // request side: offer bytes, track each accepted beat
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      stim_row_type taken;
      rsp_type      owed;
      logic         fired;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fired = req_valid && req_ready;
         if (fired) begin
            taken = feed_q.pop_front();
            owed  = track_byte(taken.rx);
            awaited_q.push_back(taken.typed ? taken.want : owed);
         end
         // a held beat keeps valid and payload, otherwise decide afresh
         if (!req_valid || fired) begin
            if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_rx_byte <= feed_q[0].rx;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // result side: random back-pressure, compare each result beat
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{event_res: rsp_event_res, data_byte: rsp_data_byte,
                     data_index: rsp_data_index, frame_class: rsp_frame_class,
                     frame_id: rsp_frame_id, frame_length: rsp_frame_length,
                     message_kind: rsp_message_kind};
            if (awaited_q.size() == 0) begin
               report_mismatch("result beat with nothing owed");
            end else begin
               want = awaited_q.pop_front();
               compare_field("event_res", seen.event_res, want.event_res);
               compare_field("data_byte", seen.data_byte, want.data_byte);
               compare_field("data_index", seen.data_index, want.data_index);
               compare_field("frame_class", seen.frame_class, want.frame_class);
               compare_field("frame_id", seen.frame_id, want.frame_id);
               compare_field("frame_length", seen.frame_length, want.frame_length);
               compare_field("message_kind", seen.message_kind, want.message_kind);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: work outstanding but no handshake on either side for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (feed_q.size() == 0 && awaited_q.size() == 0)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("tb_ubx_frame_parser: done, errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // run sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table first, no idling on either side
      foreach (DIRECTED_ROWS[i]) feed_q.push_back(DIRECTED_ROWS[i]);
      drain_all();

      // four idling phases; the sender pauses at each boundary until all results are in
      for (int ph = 0; ph < 4; ph++) begin
         unique case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         random_traffic((ph + 1) * PHASE_BEATS);
         drain_all();
      end

      // let any stray result surface, one byte takes two register stages
      repeat (6) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_ubx_frame_parser: done, clean");
      end else begin
         $display("tb_ubx_frame_parser: done, errors");
      end
      $finish;
   end

endmodule
